// ===== rtl/core/mcbc_pkg.sv =====
// Shared constants for the multi-click button counter.
package mcbc_pkg;

    localparam int RUN_BITS_DEF   = 8;
    localparam int TALLY_BITS_DEF = 4;

    localparam int CFG_W    = 8;
    localparam int REPORT_W = 5;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam int REG_IDX_W = 2;

    typedef logic [CFG_W-1:0]           cfg_t;
    typedef logic signed [REPORT_W-1:0] report_t;
    typedef logic [REG_IDX_W-1:0]       reg_idx_t;

    // Register map, index = paddr[3:2]
    localparam reg_idx_t REG_PRESS_MIN   = 2'd0;
    localparam reg_idx_t REG_PRESS_MAX   = 2'd1;
    localparam reg_idx_t REG_RELEASE_MIN = 2'd2;
    localparam reg_idx_t REG_RELEASE_MAX = 2'd3;

    localparam cfg_t PRESS_MIN_RST   = 8'd1;
    localparam cfg_t PRESS_MAX_RST   = 8'd10;
    localparam cfg_t RELEASE_MIN_RST = 8'd1;
    localparam cfg_t RELEASE_MAX_RST = 8'd5;

    localparam report_t REPORT_NONE = -5'sd1;
    localparam report_t REPORT_ZERO = 5'sd0;
    localparam int      REPORT_MAX  = 15;

endpackage

// ===== rtl/core/multi_click_button_counter.sv =====
// Multi-click button counter: run counters, click window check and burst report.
//
//  channel | signals                                  | item
//  --------+------------------------------------------+-------------------------------
//  in      | in_valid, in_ready, pressed, clear_report | one frame sample
//  out     | out_valid, out_ready, reported_clicks     | report value after that frame
//  cfg     | psel, penable, pwrite, paddr, pwdata, ... | window limits, 8 bits each
//
// One item per cycle while out_ready keeps the output register draining. Each
// sample updates the run, tally and report state through compare/increment
// logic, and its result lands in the output register on the same edge.
// Reset loads the window defaults (1, 10, 1, 5), clears all counters and sets
// the report to minus one. No clearing pass.
// in_ready stays high while the output register is empty or being drained, so a
// stalled out_ready holds one finished item and blocks only the next sample.
module multi_click_button_counter
    import mcbc_pkg::*;
#(
    parameter int RUN_BITS   = RUN_BITS_DEF,
    parameter int TALLY_BITS = TALLY_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic                pressed,
    input  logic                clear_report,

    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [REPORT_W-1:0] reported_clicks,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    // Common width for run-vs-window compares
    localparam int CMP_W   = (RUN_BITS > CFG_W) ? RUN_BITS : CFG_W;
    // Common width for clamping the tally into the report field
    localparam int TEXT_W  = (TALLY_BITS > REPORT_W) ? TALLY_BITS : REPORT_W;

    localparam logic [RUN_BITS-1:0]   RUN_MAX   = {RUN_BITS{1'b1}};
    localparam logic [TALLY_BITS-1:0] TALLY_MAX = {TALLY_BITS{1'b1}};
    localparam logic [TEXT_W-1:0]     REP_MAX_X = TEXT_W'(REPORT_MAX);

    // ---------------- configuration registers ----------------
    cfg_t press_min_reg, press_max_reg, release_min_reg, release_max_reg;
    reg_idx_t cfg_idx;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_min_reg   <= PRESS_MIN_RST;
            press_max_reg   <= PRESS_MAX_RST;
            release_min_reg <= RELEASE_MIN_RST;
            release_max_reg <= RELEASE_MAX_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_PRESS_MIN:   press_min_reg   <= pwdata[CFG_W-1:0];
                REG_PRESS_MAX:   press_max_reg   <= pwdata[CFG_W-1:0];
                REG_RELEASE_MIN: release_min_reg <= pwdata[CFG_W-1:0];
                REG_RELEASE_MAX: release_max_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_PRESS_MIN:   prdata = APB_DW'(press_min_reg);
            REG_PRESS_MAX:   prdata = APB_DW'(press_max_reg);
            REG_RELEASE_MIN: prdata = APB_DW'(release_min_reg);
            REG_RELEASE_MAX: prdata = APB_DW'(release_max_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------- frame state ----------------
    logic [RUN_BITS-1:0]   press_run_reg, press_run_next;
    logic [RUN_BITS-1:0]   release_run_reg, release_run_next;
    logic [RUN_BITS-1:0]   last_press_reg, last_press_next;
    logic [TALLY_BITS-1:0] tally_reg, tally_next;
    report_t               report_reg, report_next;
    logic                  taken_reg, taken_next;
    logic                  zero_pend_reg, zero_pend_next;

    logic                  out_valid_reg;
    report_t               out_data_reg;

    logic                  accept;
    logic                  in_window;
    logic [TEXT_W-1:0]     tally_x;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        press_run_next   = press_run_reg;
        release_run_next = release_run_reg;
        last_press_next  = last_press_reg;
        tally_next       = tally_reg;
        taken_next       = taken_reg;
        zero_pend_next   = zero_pend_reg;
        report_next      = clear_report ? REPORT_NONE : report_reg;

        if (pressed)
        begin
            if (press_run_reg != RUN_MAX)
                press_run_next = press_run_reg + 1'b1;
            release_run_next = '0;
            taken_next       = 1'b0;
        end
        else
        begin
            // falling edge of a press: keep its length
            if (press_run_reg != '0)
            begin
                last_press_next = press_run_reg;
                press_run_next  = '0;
            end
            if (release_run_reg != RUN_MAX)
                release_run_next = release_run_reg + 1'b1;
        end

        in_window = (CMP_W'(last_press_next)  >= CMP_W'(press_min_reg))
                 && (CMP_W'(last_press_next)  <= CMP_W'(press_max_reg))
                 && (CMP_W'(release_run_next) >= CMP_W'(release_min_reg))
                 && (CMP_W'(release_run_next) <= CMP_W'(release_max_reg));

        // one click per press
        if (in_window && !taken_next)
        begin
            if (tally_next != TALLY_MAX)
                tally_next = tally_next + 1'b1;
            taken_next = 1'b1;
        end

        // a report lasts one frame, then reads zero
        if (zero_pend_reg)
        begin
            report_next    = REPORT_ZERO;
            zero_pend_next = 1'b0;
        end

        // burst over: publish the tally, clamped to the field
        tally_x = TEXT_W'(tally_next);
        if ((CMP_W'(release_run_next) > CMP_W'(release_max_reg)) && (tally_next != '0))
        begin
            report_next    = (tally_x > REP_MAX_X) ? report_t'(REPORT_MAX)
                                                   : report_t'(tally_x[REPORT_W-1:0]);
            tally_next     = '0;
            zero_pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_run_reg   <= '0;
            release_run_reg <= '0;
            last_press_reg  <= '0;
            tally_reg       <= '0;
            report_reg      <= REPORT_NONE;
            taken_reg       <= 1'b0;
            zero_pend_reg   <= 1'b0;
        end
        else if (accept)
        begin
            press_run_reg   <= press_run_next;
            release_run_reg <= release_run_next;
            last_press_reg  <= last_press_next;
            tally_reg       <= tally_next;
            report_reg      <= report_next;
            taken_reg       <= taken_next;
            zero_pend_reg   <= zero_pend_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= report_next;
    end

    assign out_valid       = out_valid_reg;
    assign reported_clicks = out_data_reg;

`ifndef SYNTHESIS
    a_press_release_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !((press_run_reg != '0) && (release_run_reg != '0)))
        else $error("press and release runs both nonzero");

    a_zero_pend_state: assert property (@(posedge clk) disable iff (!rst_n)
        zero_pend_reg |-> ((report_reg > REPORT_ZERO) && (tally_reg == '0)))
        else $error("pending zero without a fresh report");

    a_accept_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (out_valid_reg && (out_data_reg == report_reg)))
        else $error("result register does not match state after accept");

    a_no_accept_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(tally_reg) && $stable(report_reg))
        else $error("state changed without an accepted item");
`endif

endmodule
